[rtl/htach_pkg.sv]
package htach_pkg;

   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 88;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 20;
   localparam int RPM_W       = 20;

   localparam logic [15:0]      MS_PER_MIN = 16'd60000;
   localparam logic [RPM_W-1:0] RPM_MAX    = 20'hFFFFF;

   localparam logic [CSR_INDEX_W-1:0] CSR_THR_HIGH     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_THR_LOW      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ZERO_TIMEOUT = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_STATIONARY   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_STABLE = 3'd4;

   localparam logic [15:0]      THR_HIGH_RESET     = 16'd30000;
   localparam logic [15:0]      THR_LOW_RESET      = 16'd22000;
   localparam logic [15:0]      ZERO_TIMEOUT_RESET = 16'd2000;
   localparam logic [RPM_W-1:0] STATIONARY_RESET   = 20'd1920;
   localparam logic [RPM_W-1:0] START_STABLE_RESET = 20'd14400;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_DIV,
      ST_TMO,
      ST_FIN
   } htach_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic eval;
      logic div_step;
      logic tmo;
      logic fin;
   } htach_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_cmd;
      logic start_div;
      logic div_last;
   } htach_stat_type;

endpackage

[rtl/hall_tachometer_hysteresis.sv]
// Hall-sensor tachometer with a hysteresis comparator and period-to-rpm conversion.
// Input channel req_: one word per sample. tuser is the command (0 sample,
// 1 clear turn counter); tdata carries the raw reading and a millisecond time.
// Result channel rsp_: exactly one word per input word, in order, holding rpm
// (fixed point with RPM_FRAC_BITS fraction bits), comparator level, stationary
// flag, turn count and accumulated runtime.
// Configuration channel csr_: always ready; write only while no word is in flight.
// After the accept, a clear command passes the states EVAL and FIN, a sample
// without a timed edge passes EVAL, TMO and FIN, and a timed rising edge passes
// EVAL, DIV, TMO and FIN, where the bit-serial restoring divider makes one quotient
// bit per cycle. One word is in work at a time, so a new word is accepted only
// once the previous word has left FIN.
// The result register decouples the two sides: a new word is accepted while the
// previous result waits; the final step of the next word waits for rsp_tready.
// Synchronous reset restores the register defaults and clears all tachometer
// state and the result valid flag.
module hall_tachometer_hysteresis #(
   parameter int RPM_FRAC_BITS = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic                              req_tuser,  // cmd
   input  logic [htach_pkg::REQ_TDATA_W-1:0] req_tdata,  // hall_raw[15:0], now_ms[47:16]
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // rpm_value[19:0], hall_level[20], is_stationary[21], turn_count[53:22],
   // runtime_total_ms[85:54], zero fill[87:86]
   output logic [htach_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [htach_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [htach_pkg::CSR_DATA_W-1:0]  csr_data
);
   import htach_pkg::*;

   htach_cmd_type  cmd;
   htach_stat_type stat;

   assign csr_ready = 1'b1;

   htach_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   htach_dpath #(
      .RPM_FRAC_BITS (RPM_FRAC_BITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

endmodule

[rtl/htach_ctrl.sv]
module htach_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  htach_pkg::htach_stat_type stat,
   output htach_pkg::htach_cmd_type  cmd
);
   import htach_pkg::*;

   htach_state_type state_ff, state_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (stat.is_cmd) state_in = ST_FIN;
            else if (stat.start_div) state_in = ST_DIV;
            else state_in = ST_TMO;
         end
         ST_DIV: begin
            if (stat.div_last) state_in = ST_TMO;
         end
         ST_TMO: begin
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_EVAL: cmd.eval     = 1'b1;
         ST_DIV:  cmd.div_step = 1'b1;
         ST_TMO:  cmd.tmo      = 1'b1;
         ST_FIN:  cmd.fin      = out_free;
         default: cmd = '0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.fin) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

[rtl/htach_dpath.sv]
module htach_dpath #(
   parameter int RPM_FRAC_BITS = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  htach_pkg::htach_cmd_type            cmd,
   output htach_pkg::htach_stat_type           stat,
   input  logic                                req_tuser,
   input  logic [htach_pkg::REQ_TDATA_W-1:0]   req_tdata,
   output logic [htach_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input  logic                                csr_valid,
   input  logic [htach_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [htach_pkg::CSR_DATA_W-1:0]    csr_data
);
   import htach_pkg::*;

   localparam int DW = 16 + RPM_FRAC_BITS;
   localparam int CW = $clog2(DW);
   localparam logic [DW-1:0] DIVIDEND = DW'(MS_PER_MIN) << RPM_FRAC_BITS;

   // Configuration registers.
   logic [15:0]      thr_high_ff, thr_high_in;
   logic [15:0]      thr_low_ff, thr_low_in;
   logic [15:0]      timeout_ff, timeout_in;
   logic [RPM_W-1:0] stat_rpm_ff, stat_rpm_in;
   logic [RPM_W-1:0] start_rpm_ff, start_rpm_in;

   // Captured input word.
   logic        item_cmd_ff, item_cmd_in;
   logic [15:0] item_raw_ff, item_raw_in;
   logic [31:0] item_now_ff, item_now_in;

   // Tachometer state.
   logic             level_ff, level_in;
   logic             edge_valid_ff, edge_valid_in;
   logic             upd_valid_ff, upd_valid_in;
   logic [31:0]      last_edge_ff, last_edge_in;
   logic [31:0]      last_upd_ff, last_upd_in;
   logic [31:0]      turns_ff, turns_in;
   logic [31:0]      runtime_ff, runtime_in;
   logic [RPM_W-1:0] rpm_hold_ff, rpm_hold_in;

   // Restoring divider.
   logic [31:0]   dvsr_ff, dvsr_in;
   logic [31:0]   rem_ff, rem_in;
   logic [DW-1:0] quo_ff, quo_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   // Result register.
   logic [RSP_TDATA_W-1:0] out_ff, out_in;

   logic             rise, fall;
   logic [31:0]      edge_dt, since_edge, runtime_add;
   logic [32:0]      rem_sh;
   logic             take;
   logic [31:0]      rem_nx;
   logic [DW-1:0]    quo_nx;
   logic [31:0]      quo_wide;
   logic [RPM_W-1:0] rpm_div;

   assign rise       = !level_ff && (item_raw_ff >= thr_high_ff);
   assign fall       = level_ff && (item_raw_ff <= thr_low_ff);
   assign edge_dt    = item_now_ff - last_edge_ff;
   assign since_edge = item_now_ff - last_edge_ff;

   assign rem_sh   = {rem_ff, quo_ff[DW-1]};
   assign take     = rem_sh >= {1'b0, dvsr_ff};
   assign rem_nx   = take ? 32'(rem_sh - {1'b0, dvsr_ff}) : rem_sh[31:0];
   assign quo_nx   = {quo_ff[DW-2:0], take};
   assign quo_wide = 32'(quo_nx);
   assign rpm_div  = (quo_wide > 32'(RPM_MAX)) ? RPM_MAX : quo_wide[RPM_W-1:0];

   assign runtime_add = (upd_valid_ff && (rpm_hold_ff > start_rpm_ff)) ?
                        item_now_ff - last_upd_ff : 32'd0;

   assign stat.is_cmd    = item_cmd_ff;
   assign stat.start_div = rise && edge_valid_ff && (edge_dt != 32'd0);
   assign stat.div_last  = cnt_ff == CW'(DW - 1);

   always_comb begin
      thr_high_in  = thr_high_ff;
      thr_low_in   = thr_low_ff;
      timeout_in   = timeout_ff;
      stat_rpm_in  = stat_rpm_ff;
      start_rpm_in = start_rpm_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_THR_HIGH:     thr_high_in  = csr_data[15:0];
            CSR_THR_LOW:      thr_low_in   = csr_data[15:0];
            CSR_ZERO_TIMEOUT: timeout_in   = csr_data[15:0];
            CSR_STATIONARY:   stat_rpm_in  = csr_data;
            CSR_START_STABLE: start_rpm_in = csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      item_cmd_in   = item_cmd_ff;
      item_raw_in   = item_raw_ff;
      item_now_in   = item_now_ff;
      level_in      = level_ff;
      edge_valid_in = edge_valid_ff;
      upd_valid_in  = upd_valid_ff;
      last_edge_in  = last_edge_ff;
      last_upd_in   = last_upd_ff;
      turns_in      = turns_ff;
      runtime_in    = runtime_ff;
      rpm_hold_in   = rpm_hold_ff;
      dvsr_in       = dvsr_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      cnt_in        = cnt_ff;
      out_in        = out_ff;

      if (cmd.load) begin
         item_cmd_in = req_tuser;
         item_raw_in = req_tdata[15:0];
         item_now_in = req_tdata[47:16];
      end

      if (cmd.eval) begin
         if (item_cmd_ff) begin
            turns_in = 32'd0;
         end else if (rise) begin
            level_in      = 1'b1;
            turns_in      = turns_ff + 32'd1;
            last_edge_in  = item_now_ff;
            edge_valid_in = 1'b1;
            dvsr_in       = edge_dt;
            rem_in        = 32'd0;
            quo_in        = DIVIDEND;
            cnt_in        = '0;
         end else if (fall) begin
            level_in = 1'b0;
         end
      end

      if (cmd.div_step) begin
         rem_in = rem_nx;
         quo_in = quo_nx;
         cnt_in = cnt_ff + CW'(1);
         if (stat.div_last) rpm_hold_in = rpm_div;
      end

      // The edge just taken has zero age, so only stale or missing edges clear rpm.
      if (cmd.tmo) begin
         if (!edge_valid_ff || (since_edge > {16'd0, timeout_ff})) rpm_hold_in = '0;
      end

      if (cmd.fin) begin
         if (!item_cmd_ff) begin
            runtime_in   = runtime_ff + runtime_add;
            last_upd_in  = item_now_ff;
            upd_valid_in = 1'b1;
         end
         out_in = {2'b00,
                   item_cmd_ff ? runtime_ff : runtime_ff + runtime_add,
                   turns_ff,
                   rpm_hold_ff < stat_rpm_ff,
                   level_ff,
                   rpm_hold_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_high_ff   <= THR_HIGH_RESET;
         thr_low_ff    <= THR_LOW_RESET;
         timeout_ff    <= ZERO_TIMEOUT_RESET;
         stat_rpm_ff   <= STATIONARY_RESET;
         start_rpm_ff  <= START_STABLE_RESET;
         level_ff      <= 1'b0;
         edge_valid_ff <= 1'b0;
         upd_valid_ff  <= 1'b0;
         last_edge_ff  <= 32'd0;
         last_upd_ff   <= 32'd0;
         turns_ff      <= 32'd0;
         runtime_ff    <= 32'd0;
         rpm_hold_ff   <= '0;
         cnt_ff        <= '0;
      end else begin
         thr_high_ff   <= thr_high_in;
         thr_low_ff    <= thr_low_in;
         timeout_ff    <= timeout_in;
         stat_rpm_ff   <= stat_rpm_in;
         start_rpm_ff  <= start_rpm_in;
         level_ff      <= level_in;
         edge_valid_ff <= edge_valid_in;
         upd_valid_ff  <= upd_valid_in;
         last_edge_ff  <= last_edge_in;
         last_upd_ff   <= last_upd_in;
         turns_ff      <= turns_in;
         runtime_ff    <= runtime_in;
         rpm_hold_ff   <= rpm_hold_in;
         cnt_ff        <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      item_cmd_ff <= item_cmd_in;
      item_raw_ff <= item_raw_in;
      item_now_ff <= item_now_in;
      dvsr_ff     <= dvsr_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      out_ff      <= out_in;
   end

   assign rsp_tdata = out_ff;

endmodule

[rtl/htach_checker.sv]
module htach_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [htach_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import htach_pkg::*;

   // A stalled result word must hold.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed or dropped while stalled");

   // Reset empties the result register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // Only one word is in work: the input closes right after an accept.
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input accepted again while a word is in work");

   // A new result appears only at the end of a word's work, never while idle.
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result appeared without a word in work");

endmodule

bind hall_tachometer_hysteresis htach_checker u_htach_checker (.*);
